// ===== hdl/afl_pkg.sv =====
// Shared constants, types and the coefficient table for the 29-tap low-pass FIR.
// Used by afl_cell, afl_mac and adc_fir_lowpass_29tap_unit.
package afl_pkg;

    localparam int TAPS_DEF  = 29;
    localparam int MAX_TAPS  = 64;
    localparam int RAW_W     = 12;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int FRAC_BITS = 15;
    localparam int OUT_W     = 16;
    localparam int PROD_W    = SAMPLE_W + 1 + COEF_W;
    localparam int TABLE_LEN = 29;

    localparam logic signed [COEF_W-1:0] COEF_TABLE [TABLE_LEN] = '{
        -16'sd60,   -16'sd52,   16'sd0,     16'sd121,   16'sd265,
        16'sd280,   16'sd0,     -16'sd570,  -16'sd1119, -16'sd1093,
        16'sd0,     16'sd2216,  16'sd4987,  16'sd7305,  16'sd8208,
        16'sd7305,  16'sd4987,  16'sd2216,  16'sd0,     -16'sd1093,
        -16'sd1119, -16'sd570,  16'sd0,     16'sd280,   16'sd265,
        16'sd121,   16'sd0,     -16'sd52,   -16'sd60
    };

    typedef struct packed {
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    typedef struct packed {
        logic             done;
        logic [OUT_W-1:0] result;
    } t_mac_out;

    function automatic logic signed [COEF_W-1:0] coef_q15(input int k);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (k >= 0 && k < TABLE_LEN) begin
            c = COEF_TABLE[k];
        end
        return c;
    endfunction

    function automatic logic [SAMPLE_W-1:0] widen12(input logic [RAW_W-1:0] raw);
        return {raw, raw[RAW_W-1 -: 4]};
    endfunction

endpackage

// ===== hdl/afl_cell.sv =====
// One delay-line cell: holds a widened sample and takes its neighbor's on shift.
// Depends on afl_pkg.
module afl_cell
    import afl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [SAMPLE_W-1:0] i_data,
    output logic [SAMPLE_W-1:0] o_data
);

    logic [SAMPLE_W-1:0] r_data;
    logic [SAMPLE_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift) begin
            n_data = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== hdl/afl_mac.sv =====
// Shared multiply-accumulate with rounding and saturation of the finished sum.
// Depends on afl_pkg.
module afl_mac
    import afl_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  logic [SAMPLE_W-1:0]      i_tap,
    input  logic signed [COEF_W-1:0] i_coef,
    output t_mac_out                 o_mac
);

    localparam int ACC_W = PROD_W + $clog2(TAPS);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pvalid;
    logic                     r_pfirst;
    logic                     r_plast;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     r_done;

    logic signed [ACC_W:0]    w_rnd;
    logic signed [ACC_W:0]    w_q;
    logic [OUT_W-1:0]         w_result;

    always_ff @(posedge i_clk) begin
        r_prod   <= signed'({1'b0, i_tap}) * i_coef;
        r_pfirst <= i_ctl.first;
        r_plast  <= i_ctl.last;
        r_acc    <= n_acc;
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_pvalid <= i_ctl.valid;
            r_done   <= r_pvalid && r_plast;
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (r_pvalid) begin
            if (r_pfirst) begin
                n_acc = ACC_W'(r_prod);
            end else begin
                n_acc = r_acc + ACC_W'(r_prod);
            end
        end
    end

    always_comb begin
        w_rnd = (ACC_W+1)'(r_acc) + (ACC_W+1)'(1 << (FRAC_BITS - 1));
        w_q   = w_rnd >>> FRAC_BITS;
        if (w_rnd[ACC_W]) begin
            w_result = '0;
        end else if (|w_q[ACC_W:OUT_W]) begin
            w_result = '1;
        end else begin
            w_result = w_q[OUT_W-1:0];
        end
    end

    assign o_mac.done   = r_done;
    assign o_mac.result = w_result;

endmodule

// ===== hdl/adc_fir_lowpass_29tap_unit.sv =====
// Top level of the 29-tap low-pass FIR for 12-bit ADC samples.
// Depends on afl_pkg, afl_cell and afl_mac.
//
// Input channel: i_valid / o_stall with i_raw_sample; a transfer happens at a
// clock edge with i_valid high and o_stall low. Output channel: o_valid /
// i_stall with o_filtered_sample, one result per input sample.
// The sample is widened to 16 bits and loaded into a chain of TAPS cells.
// The chain then rotates once per cycle through all TAPS cells, presenting one tap
// per cycle to a single shared multiply-accumulate, and ends where it began.
// o_stall stays high from the input transfer until the result leaves the hold
// state, so no new sample is taken while one is being filtered; the one
// multiplier has two register stages, product and accumulator.
// A finished result waits in the output register while the next sample is
// taken and filtered; if the receiver still stalls when the next result is
// ready, the block holds it and keeps o_stall high until the output drains.
// Reset (i_rst_n low, synchronous) clears all cells to zero, drops any
// pending result and returns the block to idle.
module adc_fir_lowpass_29tap_unit
    import afl_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [RAW_W-1:0]  i_raw_sample,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [OUT_W-1:0]  o_filtered_sample
);

    localparam int CNT_W = $clog2(TAPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_HOLD
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_ovalid;
    logic [OUT_W-1:0]    r_out;

    logic                w_load;
    logic                w_run;
    t_cell_ctl           w_cell_ctl;
    logic [SAMPLE_W-1:0] w_chain [TAPS];
    logic [SAMPLE_W-1:0] w_head;
    t_mac_ctl            w_mac_ctl;
    t_mac_out            w_mac;
    logic                w_out_free;

    assign w_load     = (r_state == S_IDLE) && i_valid;
    assign w_run      = (r_state == S_RUN);
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_cell_ctl.shift = w_load || w_run;
    assign w_head     = w_load ? widen12(i_raw_sample) : w_chain[TAPS-1];

    genvar g;
    generate
        for (g = 0; g < TAPS; g++) begin : g_cell
            afl_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_cell_ctl),
                .i_data ((g == 0) ? w_head : w_chain[(g == 0) ? 0 : g-1]),
                .o_data (w_chain[g])
            );
        end
    endgenerate

    assign w_mac_ctl.valid = w_run;
    assign w_mac_ctl.first = w_run && (r_cnt == CNT_W'(TAPS - 1));
    assign w_mac_ctl.last  = w_run && (r_cnt == '0);

    afl_mac #(
        .TAPS(TAPS)
    ) u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_mac_ctl),
        .i_tap  (w_chain[TAPS-1]),
        .i_coef (coef_q15(int'(r_cnt))),
        .o_mac  (w_mac)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_out    <= '0;
        end else begin
            if (r_ovalid && !i_stall && (r_state != S_HOLD)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cnt   <= CNT_W'(TAPS - 1);
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_mac.done) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_out_free) begin
                        r_out    <= w_mac.result;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_ovalid;
    assign o_filtered_sample = r_out;

endmodule
